// ----- hdl/pv_string_operating_point_assert.svh -----
// Assertion macros for the checker file.
`ifndef PV_STRING_OPERATING_POINT_ASSERT_SVH
`define PV_STRING_OPERATING_POINT_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, quiet during reset.
`define PVSOP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pvsop assertion failed");

// Next-cycle implication, clocked on clk_i, quiet during reset.
`define PVSOP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pvsop assertion failed");

`endif

// ----- hdl/pvsop_pkg.sv -----
// Shared constants, codes and helpers for the PV string operating point block.
package pvsop_pkg;

  localparam int CELLS_DEF = 12;

  localparam logic [22:0] DROP_RST = 23'd98304;  // 1.5 V in Q7.16

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_SOLVE = 1'b1;

  localparam logic REG_DIODE_PRESENT = 1'b0;
  localparam logic REG_DIODE_DROP    = 1'b1;

  localparam logic signed [39:0] V_MAX = 40'sd8388607;
  localparam logic signed [39:0] V_MIN = -40'sd8388608;

  function automatic logic signed [23:0] sat24(input logic signed [39:0] v);
    logic signed [23:0] r;
    if (v > V_MAX) begin
      r = 24'sh7FFFFF;
    end else if (v < V_MIN) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

// ----- hdl/pvsop_div.sv -----
// Serial restoring divider: signed dividend by small unsigned count, truncating.
module pvsop_div import pvsop_pkg::*; #(
  parameter int DW = 32,
  parameter int CW = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [DW-1:0] dividend_i,
  input  logic        [CW-1:0] divisor_i,
  output logic                 done_o,
  output logic signed [DW-1:0] quotient_o
);

  localparam int SW = $clog2(DW + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic          neg_q, neg_d;
  logic [DW-1:0] mag_q, mag_d;
  logic [CW-1:0] rem_q, rem_d;
  logic [CW-1:0] div_q, div_d;
  logic [SW-1:0] step_q, step_d;
  logic [CW:0]   trial;
  logic          fits;

  assign trial = {rem_q, mag_q[DW-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    mag_d  = mag_q;
    rem_d  = rem_q;
    div_d  = div_q;
    step_d = step_q;
    if (start_i) begin
      busy_d = 1'b1;
      neg_d  = dividend_i[DW-1];
      mag_d  = dividend_i[DW-1] ? DW'(-dividend_i) : DW'(dividend_i);
      rem_d  = '0;
      div_d  = divisor_i;
      step_d = '0;
    end else if (busy_q) begin
      rem_d  = fits ? CW'(trial - {1'b0, div_q}) : CW'(trial);
      mag_d  = {mag_q[DW-2:0], fits};
      step_d = step_q + 1'b1;
      if (step_q == SW'(DW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    mag_q <= mag_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? -$signed(mag_q) : $signed(mag_q);

endmodule

// ----- hdl/pv_string_operating_point.sv -----
// PV string operating point solver: top level with cell store and sequencer.
//
// Usage
//   Input channel (in_valid_i / in_ready_o) carries one request per handshake.
//   A load request (opcode 0) writes one cell's Isc, Voc and Vbr into the
//   store and yields nothing. A slot of CELLS or more is
//   dropped. A solve request (opcode 1) yields CELLS results in slot order on
//   the output channel (out_valid_o / out_ready_i), last_o on the final one.
//   Configuration (cfg_we_i, cfg_idx_i, cfg_wdata_i) is to be written while
//   idle; the block itself does not enforce this.
// Timing
//   in_ready_o is high only while the sequencer is idle. A solve scans the
//   cell store through the accumulators, one cell per cycle:
//     diode off : one scan, at most one divide, then the results one by one.
//     diode on  : CELLS passes of key fetch, scan and test (one pass per
//                 candidate group key), at most one divide, then the results.
// Reset and stall
//   Reset returns the sequencer to idle, empties the output register and sets
//   diode_present = 1, diode_drop = 1.5 V; the cell store is undefined until
//   loaded. A stalled receiver holds the output register; the sequencer waits.
module pv_string_operating_point import pvsop_pkg::*; #(
  parameter int CELLS = CELLS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [22:0]        cfg_wdata_i,
  // request channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               opcode_i,
  input  logic [3:0]         cell_slot_i,
  input  logic [22:0]        short_circuit_current_i,
  input  logic signed [23:0] open_circuit_voltage_i,
  input  logic signed [23:0] breakdown_voltage_i,
  input  logic signed [23:0] string_current_i,
  input  logic signed [23:0] string_voltage_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [3:0]         out_slot_o,
  output logic signed [23:0] cell_voltage_o,
  output logic signed [23:0] cell_current_o,
  output logic signed [23:0] diode_current_o,
  output logic               last_o
);

  localparam int IW = $clog2(CELLS);
  localparam int CW = $clog2(CELLS + 1);
  localparam int AW = 24 + $clog2(CELLS) + 2;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_KEY   = 4'd1;  // fetch candidate key
  localparam logic [3:0] S_KEYW  = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;  // stream the store through the accumulator
  localparam logic [3:0] S_DRAIN = 4'd4;
  localparam logic [3:0] S_EVAL  = 4'd5;  // diode on: test candidate group
  localparam logic [3:0] S_DIVS  = 4'd6;  // launch divide, settle output controls
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_OUTR  = 4'd8;
  localparam logic [3:0] S_OUTW  = 4'd9;

  logic [3:0] state_q, state_d;

  // configuration registers
  logic        diode_present_q;
  logic [22:0] diode_drop_q;

  // cell store
  logic        [22:0] isc_mem [CELLS];
  logic signed [23:0] voc_mem [CELLS];
  logic signed [23:0] vbr_mem [CELLS];
  logic        [22:0] rd_isc_q;
  logic signed [23:0] rd_voc_q;
  logic signed [23:0] rd_vbr_q;
  logic [IW-1:0]      rd_addr;
  logic               pvld_q;

  logic [IW-1:0] idx_q, idx_d;
  logic [IW-1:0] j_q, j_d;

  logic signed [23:0] iin_q, vin_q;
  logic               don_q;
  logic signed [24:0] key_q, key_d;
  logic signed [AW-1:0] acc_a_q, acc_a_d;
  logic signed [AW-1:0] acc_b_q, acc_b_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic                 found_q, found_d;
  logic [22:0]          best_isc_q, best_isc_d;
  logic signed [AW-1:0] best_x_q, best_x_d;
  logic [CW-1:0]        best_cnt_q, best_cnt_d;
  logic signed [23:0]   quot_q, quot_d;
  logic signed [23:0]   idiode_q, idiode_d;
  logic signed [23:0]   curr_q, curr_d;
  logic                 allbrk_q, allbrk_d;

  logic               out_valid_q, out_valid_d;
  logic [3:0]         out_slot_q, out_slot_d;
  logic signed [23:0] out_volt_q, out_volt_d;
  logic signed [23:0] out_curr_q, out_curr_d;
  logic signed [23:0] out_diode_q, out_diode_d;
  logic               out_last_q, out_last_d;

  // divider
  logic                 div_start;
  logic signed [AW-1:0] div_dividend;
  logic [CW-1:0]        div_divisor;
  logic                 div_done;
  logic signed [AW-1:0] div_quot;

  logic               in_fire, out_free;
  logic signed [24:0] isc_s;
  logic               lt, gt, eq;
  logic signed [23:0] add_v;
  logic signed [AW-1:0] drop_ext, x_on, x_off;
  logic signed [23:0] iwork;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  assign in_ready_o = (state_q == S_IDLE);

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diode_present_q <= 1'b1;
      diode_drop_q    <= DROP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DIODE_PRESENT: diode_present_q <= cfg_wdata_i[0];
        REG_DIODE_DROP:    diode_drop_q    <= cfg_wdata_i;
        default:           ;
      endcase
    end
  end

  // store: one write port, one registered read port
  assign rd_addr = (state_q == S_KEY) ? idx_q : j_q;

  always_ff @(posedge clk_i) begin
    if (in_fire && opcode_i == OP_LOAD && 32'(cell_slot_i) < CELLS) begin
      isc_mem[IW'(cell_slot_i)] <= short_circuit_current_i;
      voc_mem[IW'(cell_slot_i)] <= open_circuit_voltage_i;
      vbr_mem[IW'(cell_slot_i)] <= breakdown_voltage_i;
    end
    rd_isc_q <= isc_mem[rd_addr];
    rd_voc_q <= voc_mem[rd_addr];
    rd_vbr_q <= vbr_mem[rd_addr];
  end

  // compare of the cell read against the current group key
  assign isc_s = $signed({2'b00, rd_isc_q});
  assign lt    = isc_s < key_q;
  assign gt    = isc_s > key_q;
  assign eq    = !lt && !gt;
  // cells below the key sit at Vbr, cells above at Voc
  assign add_v = lt ? rd_vbr_q : (gt ? rd_voc_q : 24'sd0);

  assign drop_ext = $signed(AW'(diode_drop_q));
  assign x_on     = -drop_ext - acc_a_q;        // clamp candidate for this group
  assign x_off    = AW'(vin_q) - acc_a_q;       // voltage left for the matching group
  assign iwork    = found_q ? $signed({1'b0, best_isc_q}) : iin_q;

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    j_d        = j_q;
    key_d      = key_q;
    acc_a_d    = acc_a_q;
    acc_b_d    = acc_b_q;
    cnt_d      = cnt_q;
    found_d    = found_q;
    best_isc_d = best_isc_q;
    best_x_d   = best_x_q;
    best_cnt_d = best_cnt_q;
    quot_d     = quot_q;
    idiode_d   = idiode_q;
    curr_d     = curr_q;
    allbrk_d   = allbrk_q;
    div_start  = 1'b0;
    div_dividend = don_q ? best_x_q : x_off;
    div_divisor  = don_q ? best_cnt_q : cnt_q;

    out_valid_d = out_valid_q && !out_ready_i;
    out_slot_d  = out_slot_q;
    out_volt_d  = out_volt_q;
    out_curr_d  = out_curr_q;
    out_diode_d = out_diode_q;
    out_last_d  = out_last_q;

    // accumulate one streamed cell
    if (pvld_q) begin
      acc_a_d = acc_a_q + AW'(add_v);
      acc_b_d = acc_b_q + (eq ? AW'(rd_vbr_q) : '0);
      cnt_d   = cnt_q + CW'(eq);
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire && opcode_i == OP_SOLVE) begin
          idx_d   = '0;
          j_d     = '0;
          found_d = 1'b0;
          acc_a_d = '0;
          acc_b_d = '0;
          cnt_d   = '0;
          if (diode_present_q &&
              !($signed({string_voltage_i[23], string_voltage_i}) >
                -$signed({2'b00, diode_drop_q}))) begin
            state_d = S_KEY;
          end else begin
            key_d   = 25'(string_current_i);
            state_d = S_SCAN;
          end
        end
      end
      S_KEY: begin
        state_d = S_KEYW;
      end
      S_KEYW: begin
        key_d   = $signed({2'b00, rd_isc_q});
        acc_a_d = '0;
        acc_b_d = '0;
        cnt_d   = '0;
        j_d     = '0;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (j_q == IW'(CELLS - 1)) begin
          state_d = S_DRAIN;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      S_DRAIN: begin
        state_d = don_q ? S_EVAL : S_DIVS;
      end
      S_EVAL: begin
        // active group: lowest Isc whose clamp exceeds its breakdown sum
        if (x_on > acc_b_q && (!found_q || key_q[22:0] < best_isc_q)) begin
          found_d    = 1'b1;
          best_isc_d = key_q[22:0];
          best_x_d   = x_on;
          best_cnt_d = cnt_q;
        end
        if (idx_q == IW'(CELLS - 1)) begin
          state_d = S_DIVS;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_KEY;
        end
      end
      S_DIVS: begin
        j_d = '0;
        if (don_q) begin
          key_d    = $signed({2'b00, best_isc_q});
          allbrk_d = !found_q;
          curr_d   = iwork;
          idiode_d = sat24(40'(iin_q) - 40'(iwork));
          div_start = found_q;
        end else begin
          allbrk_d = 1'b0;
          curr_d   = iin_q;
          idiode_d = '0;
          div_start = (cnt_q != '0);
        end
        state_d = div_start ? S_DIV : S_OUTR;
      end
      S_DIV: begin
        if (div_done) begin
          quot_d  = sat24(40'(div_quot));
          state_d = S_OUTR;
        end
      end
      S_OUTR: begin
        state_d = S_OUTW;
      end
      S_OUTW: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_slot_d  = 4'(j_q);
          out_volt_d  = (allbrk_q || lt) ? rd_vbr_q : (gt ? rd_voc_q : quot_q);
          out_curr_d  = curr_q;
          out_diode_d = idiode_q;
          out_last_d  = (j_q == IW'(CELLS - 1));
          if (j_q == IW'(CELLS - 1)) begin
            state_d = S_IDLE;
          end else begin
            j_d     = j_q + 1'b1;
            state_d = S_OUTR;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pvld_q      <= 1'b0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      idx_q       <= '0;
      j_q         <= '0;
    end else begin
      state_q     <= state_d;
      pvld_q      <= (state_q == S_SCAN);
      out_valid_q <= out_valid_d;
      found_q     <= found_d;
      idx_q       <= idx_d;
      j_q         <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && opcode_i == OP_SOLVE) begin
      iin_q <= string_current_i;
      vin_q <= string_voltage_i;
      don_q <= diode_present_q &&
               !($signed({string_voltage_i[23], string_voltage_i}) >
                 -$signed({2'b00, diode_drop_q}));
    end
    key_q       <= key_d;
    acc_a_q     <= acc_a_d;
    acc_b_q     <= acc_b_d;
    cnt_q       <= cnt_d;
    best_isc_q  <= best_isc_d;
    best_x_q    <= best_x_d;
    best_cnt_q  <= best_cnt_d;
    quot_q      <= quot_d;
    idiode_q    <= idiode_d;
    curr_q      <= curr_d;
    allbrk_q    <= allbrk_d;
    out_slot_q  <= out_slot_d;
    out_volt_q  <= out_volt_d;
    out_curr_q  <= out_curr_d;
    out_diode_q <= out_diode_d;
    out_last_q  <= out_last_d;
  end

  pvsop_div #(
    .DW(AW),
    .CW(CW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign out_valid_o     = out_valid_q;
  assign out_slot_o      = out_slot_q;
  assign cell_voltage_o  = out_volt_q;
  assign cell_current_o  = out_curr_q;
  assign diode_current_o = out_diode_q;
  assign last_o          = out_last_q;

endmodule

// ----- hdl/pvsop_checker.sv -----
// Port-level checker for the PV string operating point block, with its bind.
`include "pv_string_operating_point_assert.svh"

module pvsop_checker import pvsop_pkg::*; #(
  parameter int CELLS = CELLS_DEF
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               opcode_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [3:0]         out_slot_o,
  input logic signed [23:0] cell_voltage_o,
  input logic               last_o
);

  // stalled result holds
  `PVSOP_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(out_slot_o) && $stable(cell_voltage_o) && $stable(last_o))

  // a solve request makes the block busy
  `PVSOP_ASSERT_NEXT(a_solve_busy, in_valid_i && in_ready_o && opcode_i == OP_SOLVE,
    !in_ready_o)

  // a load request does not make the block busy
  `PVSOP_ASSERT_NEXT(a_load_quick, in_valid_i && in_ready_o && opcode_i == OP_LOAD,
    in_ready_o)

  // the last result carries the final slot of the store
  `PVSOP_ASSERT_IMPL(a_slot_range, out_valid_o && last_o, 32'(out_slot_o) == CELLS - 1)

endmodule

bind pv_string_operating_point pvsop_checker #(.CELLS(CELLS)) u_pvsop_checker (.*);

// ----- bench/pv_string_operating_point_tb.sv -----
// Testbench for the PV string operating point block: random loads and solves, self-checking.
module pv_string_operating_point_tb;
  import pvsop_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCELL = 12;
  localparam int DRAIN_CYCLES = 400;  // covers one full diode-on solve

  typedef struct {
    logic               op;
    logic [3:0]         slot;
    logic [22:0]        isc;
    logic signed [23:0] voc;
    logic signed [23:0] vbr;
    logic signed [23:0] iin;
    logic signed [23:0] vin;
  } request_t;

  typedef struct {
    logic [3:0]         slot;
    logic signed [23:0] volt;
    logic signed [23:0] curr;
    logic signed [23:0] idio;
    logic               last;
  } cell_result_t;

  // Scoreboard: own copy of the cell store and registers, queue of expected cell results.
  class op_point_sb;
    logic [22:0]        isc_mem [NCELL];
    logic signed [23:0] voc_mem [NCELL];
    logic signed [23:0] vbr_mem [NCELL];
    logic               has_diode;
    logic [22:0]        drop_v;
    cell_result_t       expected_q [$];
    int                 errors;

    function new();
      has_diode = 1'b1;
      drop_v    = DROP_RST;
      errors    = 0;
      foreach (isc_mem[i]) begin
        isc_mem[i] = '0;
        voc_mem[i] = '0;
        vbr_mem[i] = '0;
      end
    endfunction

    function void write_reg(logic idx, logic [22:0] d);
      if (idx == REG_DIODE_PRESENT) has_diode = d[0];
      else drop_v = d;
    endfunction

    function longint clip24(longint v);
      if (v > 64'sd8388607) return 64'sd8388607;
      if (v < -64'sd8388608) return -64'sd8388608;
      return v;
    endfunction

    function void note_request(request_t r);
      int           order [NCELL];
      int           gstart [NCELL];
      int           gcnt [NCELL];
      longint       gisc [NCELL];
      longint       gvoc [NCELL];
      longint       gvbr [NCELL];
      longint       gx [NCELL];
      longint       volt [NCELL];
      longint       curr [NCELL];
      longint       iin, vin, drop, idio, svoc, svbr, post, prev, x, share, iwork;
      int           ng, j, c, lb, act;
      bit           brk;
      cell_result_t res;
      if (r.op == OP_LOAD) begin
        if (r.slot < NCELL) begin
          isc_mem[r.slot] = r.isc;
          voc_mem[r.slot] = r.voc;
          vbr_mem[r.slot] = r.vbr;
        end
        return;
      end
      iin  = r.iin;
      vin  = r.vin;
      drop = drop_v;
      ng   = 0;
      // stable sort of slots by Isc
      for (int i = 0; i < NCELL; i++) begin
        j = i;
        while (j > 0 && isc_mem[order[j-1]] > isc_mem[i]) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = i;
      end
      // runs of equal Isc
      for (int i = 0; i < NCELL; i++) begin
        c = order[i];
        if (ng == 0 || gisc[ng-1] != longint'(isc_mem[c])) begin
          gstart[ng] = i;
          gcnt[ng]   = 0;
          gisc[ng]   = isc_mem[c];
          gvoc[ng]   = 0;
          gvbr[ng]   = 0;
          ng++;
        end
        gcnt[ng-1]++;
        gvoc[ng-1] += voc_mem[c];
        gvbr[ng-1] += vbr_mem[c];
      end
      if (!has_diode || vin > -drop) begin
        lb = ng;
        svoc = 0;
        svbr = 0;
        for (int g = 0; g < ng; g++) begin
          if (gisc[g] >= iin) begin
            lb = g;
            break;
          end
        end
        act = (lb < ng && gisc[lb] == iin) ? lb : -1;
        for (int g = 0; g < ng; g++) begin
          if (g == act) continue;
          brk = g < lb;
          if (brk) svbr += gvbr[g];
          else svoc += gvoc[g];
          for (int k = 0; k < gcnt[g]; k++) begin
            c = order[gstart[g] + k];
            volt[c] = brk ? longint'(vbr_mem[c]) : longint'(voc_mem[c]);
            curr[c] = iin;
          end
        end
        if (act >= 0) begin
          share = (vin - svoc - svbr) / longint'(gcnt[act]);
          for (int k = 0; k < gcnt[act]; k++) begin
            c = order[gstart[act] + k];
            volt[c] = share;
            curr[c] = iin;
          end
        end
        idio = 0;
      end else begin
        post = 0;
        prev = 0;
        act  = -1;
        for (int g = 0; g < ng; g++) post += gvoc[g];
        for (int g = 0; g < ng; g++) begin
          post -= gvoc[g];
          x = -drop - prev - post;
          gx[g] = (x < gvbr[g]) ? gvbr[g] : x;
          prev += gvbr[g];
        end
        for (int g = 0; g < ng; g++) begin
          if (gx[g] > gvbr[g]) begin
            act = g;
            break;
          end
        end
        iwork = (act >= 0) ? gisc[act] : iin;
        for (int g = 0; g < ng; g++) begin
          brk = (act < 0) || (g < act);
          for (int k = 0; k < gcnt[g]; k++) begin
            c = order[gstart[g] + k];
            if (g == act) volt[c] = gx[g] / longint'(gcnt[g]);
            else volt[c] = brk ? longint'(vbr_mem[c]) : longint'(voc_mem[c]);
            curr[c] = iwork;
          end
        end
        idio = clip24(iin - iwork);
      end
      for (int i = 0; i < NCELL; i++) begin
        res.slot = i[3:0];
        res.volt = 24'(clip24(volt[i]));
        res.curr = 24'(clip24(curr[i]));
        res.idio = idio[23:0];
        res.last = (i == NCELL - 1);
        expected_q.insert(expected_q.size(), res);
      end
    endfunction

    function void check_result(cell_result_t got);
      cell_result_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result for slot %0d", got.slot);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.slot !== want.slot) begin
        $error("out_slot: expected %0d, got %0d", want.slot, got.slot);
        errors++;
      end
      if (got.volt !== want.volt) begin
        $error("cell_voltage: expected %0d, got %0d", want.volt, got.volt);
        errors++;
      end
      if (got.curr !== want.curr) begin
        $error("cell_current: expected %0d, got %0d", want.curr, got.curr);
        errors++;
      end
      if (got.idio !== want.idio) begin
        $error("diode_current: expected %0d, got %0d", want.idio, got.idio);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic               cfg_idx_i;
  logic [22:0]        cfg_wdata_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               opcode_i;
  logic [3:0]         cell_slot_i;
  logic [22:0]        short_circuit_current_i;
  logic signed [23:0] open_circuit_voltage_i;
  logic signed [23:0] breakdown_voltage_i;
  logic signed [23:0] string_current_i;
  logic signed [23:0] string_voltage_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [3:0]         out_slot_o;
  logic signed [23:0] cell_voltage_o;
  logic signed [23:0] cell_current_o;
  logic signed [23:0] diode_current_o;
  logic               last_o;

  pv_string_operating_point DUT (.*);

  op_point_sb  sb = new();
  bit          no_gaps;        // both sides run back to back while set
  int          hold_cycles;    // one-shot long receiver stall, consumed by the receiver
  logic [22:0] isc_pool [4];   // shared Isc values, so that groups form

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Result monitor: sample handshake at the edge, values are pre-update.
  always @(posedge clk_i) begin
    cell_result_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.slot = out_slot_o;
      got.volt = cell_voltage_o;
      got.curr = cell_current_o;
      got.idio = diode_current_o;
      got.last = last_o;
      sb.check_result(got);
    end
  end

  // Receiver: random stall per result, plus the one long hold-off on request.
  initial begin
    int k;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_cycles > 0) begin
        k = hold_cycles;
        hold_cycles = 0;
      end else begin
        k = no_gaps ? 0 : $urandom_range(15);
      end
      if (k > 0) begin
        out_ready_i <= 1'b0;
        repeat (k) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Offer one request; returns in the step of its acceptance.
  task automatic send_request(request_t r);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(15);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i              <= 1'b1;
    opcode_i                <= r.op;
    cell_slot_i             <= r.slot;
    short_circuit_current_i <= r.isc;
    open_circuit_voltage_i  <= r.voc;
    breakdown_voltage_i     <= r.vbr;
    string_current_i        <= r.iin;
    string_voltage_i        <= r.vin;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(r);
  endtask

  // One register write; the caller drops cfg_we_i after the last write.
  task automatic write_cfg(logic idx, logic [22:0] d);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= d;
    @(posedge clk_i);
    sb.write_reg(idx, d);
  endtask

  // Drain: every expected result in, then the block's own tail for trailing loads.
  task automatic wait_drained();
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic request_t load_req(int slot, logic [22:0] isc, int voc, int vbr);
    request_t r;
    r.op   = OP_LOAD;
    r.slot = slot[3:0];
    r.isc  = isc;
    r.voc  = voc[23:0];
    r.vbr  = vbr[23:0];
    r.iin  = 24'($urandom);   // ignored on a load
    r.vin  = 24'($urandom);
    return r;
  endfunction

  function automatic request_t solve_req(int iin, int vin);
    request_t r;
    r.op   = OP_SOLVE;
    r.slot = 4'($urandom);    // cell fields ignored on a solve
    r.isc  = 23'($urandom);
    r.voc  = 24'($urandom);
    r.vbr  = 24'($urandom);
    r.iin  = iin[23:0];
    r.vin  = vin[23:0];
    return r;
  endfunction

  // Random request: mostly realistic cells built from a small Isc pool, some full-range noise.
  function automatic request_t random_req();
    request_t    r;
    int          pick;
    int          iin, vin;
    logic [22:0] isc;
    pick = $urandom_range(99);
    if (pick < 65) begin
      isc = ($urandom_range(9) < 8) ? isc_pool[$urandom_range(3)] : 23'($urandom);
      if ($urandom_range(9) < 8)
        r = load_req(($urandom_range(19) == 0) ? $urandom_range(15) : $urandom_range(11),
                     isc, $urandom_range(65536), -int'($urandom_range(1310720)));
      else
        r = load_req($urandom_range(15), isc, int'($urandom), int'($urandom));
      return r;
    end
    case ($urandom_range(3))
      0: iin = isc_pool[$urandom_range(3)];
      1: iin = sb.isc_mem[$urandom_range(NCELL - 1)];
      2: iin = $urandom_range(600000);
      default: iin = int'($urandom);
    endcase
    case ($urandom_range(3))
      0: vin = -int'(sb.drop_v) - int'($urandom_range(2000000));
      1: vin = -int'(sb.drop_v) + int'($urandom_range(4)) - 2;
      2: vin = int'($urandom_range(1500000)) - 500000;
      default: vin = int'($urandom);
    endcase
    return solve_req(iin, vin);
  endfunction

  initial begin
    int unsigned      drops [6];
    bit               diodes [6];
    request_t         directed [$];
    rst_ni                  <= 1'b0;
    cfg_we_i                <= 1'b0;
    cfg_idx_i               <= REG_DIODE_PRESENT;
    cfg_wdata_i             <= '0;
    in_valid_i              <= 1'b0;
    opcode_i                <= OP_LOAD;
    cell_slot_i             <= '0;
    short_circuit_current_i <= '0;
    open_circuit_voltage_i  <= '0;
    breakdown_voltage_i     <= '0;
    string_current_i        <= '0;
    string_voltage_i        <= '0;
    no_gaps     = 1'b0;
    hold_cycles = 0;
    foreach (isc_pool[i]) isc_pool[i] = 23'($urandom_range(600000));
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every slot loaded first, extremes, equal-Isc groups, ignored slots.
    directed.insert(directed.size(), load_req(0, 23'd0, 8388607, -8388608));
    directed.insert(directed.size(), load_req(1, 23'h7FFFFF, -8388608, 8388607));
    for (int s = 2; s < NCELL; s++)
      directed.insert(directed.size(), load_req(s, isc_pool[s % 3], 39321, -655360));
    directed.insert(directed.size(), load_req(12, 23'd5, 1, 1));  // out of range, dropped
    directed.insert(directed.size(), load_req(15, 23'd5, 1, 1));
    directed.insert(directed.size(), solve_req(isc_pool[0], 0));       // diode off, shared
    directed.insert(directed.size(), solve_req(isc_pool[1], -3000000)); // diode on
    directed.insert(directed.size(), solve_req(-8388608, -8388608));   // extremes, diode on
    directed.insert(directed.size(), solve_req(8388607, 8388607));     // diode off, top Isc group active
    directed.insert(directed.size(), solve_req(0, -98304));            // exactly at -drop
    directed.insert(directed.size(), solve_req(int'(isc_pool[2]) + 1, -98303));
    directed.insert(directed.size(), solve_req(8388607, -8388608));
    foreach (directed[i]) send_request(directed[i]);
    in_valid_i <= 1'b0;

    // Register settings per phase; extremes of the drop and both diode states.
    diodes = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
    drops  = '{98304, 0, 8388607, 8388607, $urandom_range(8388607), 98304};
    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      write_cfg(REG_DIODE_PRESENT, {22'd0, diodes[ph]});
      write_cfg(REG_DIODE_DROP, drops[ph][22:0]);
      cfg_we_i <= 1'b0;
      no_gaps = (ph == 2);
      for (int n = 0; n < 60; n++) begin
        if (ph == 1 && n == 10) hold_cycles = 600;  // receiver stalls, block backs up
        if (ph == 3 && n == 30) begin
          in_valid_i <= 1'b0;                        // sender pauses until drained
          @(posedge clk_i);
          while (sb.expected_q.size() != 0) @(posedge clk_i);
        end
        send_request(random_req());
      end
      in_valid_i <= 1'b0;
    end
    no_gaps = 1'b0;

    wait_drained();
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
